>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/dppa_pkg.sv
// Types and constants for the direction-pin pulse accumulator.
`default_nettype none
package dppa_pkg;

	localparam int COUNT_BITS = 16;
	localparam int TOTAL_BITS = 32;

	typedef enum logic [1:0] {
		MODE_FWD = 2'd0,
		MODE_REV = 2'd1,
		MODE_END = 2'd2
	} mode_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] counter_sample;
		logic                  dir_pin;
		logic [COUNT_BITS-1:0] dir_check_count;
	} sample_t;

	typedef struct packed {
		logic [TOTAL_BITS-1:0] pulse_total;
		logic [1:0]            dir_mode;
	} result_t;

endpackage
`default_nettype wire

>>> src/direction_pin_pulse_accumulator.sv
// Direction-pin pulse accumulator: input register, update logic, result register.
`default_nettype none
// Each item is one poll of a free-running up-counter: the counter value, the
// direction pin level and a second counter read taken when the pin was
// checked. The block keeps a wrapping 32-bit net pulse total (forward pulses
// added, pulses counted during reverse subtracted) and reports it together
// with the direction mode after every poll: one result per item, in order.
// Rate: one item per cycle sustained while result_stall is low. result_valid
// rises once the item has passed the input register and then the result
// register; the state update (up to three 16-bit modular differences folded
// into the 32-bit total) sits in the single stage between them. The input
// register keeps accepting while a finished result waits on result_stall,
// so sample_stall rises only when both the input register and the result
// register are full and the result side is stalled. Control and accumulator
// state is zero after reset, mode forward; the payload registers are not reset.
module direction_pin_pulse_accumulator
	import dppa_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    sample_valid,
	output logic         sample_stall,
	input  wire sample_t sample,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	// input register
	logic    valid_s1;
	sample_t item_s1;

	// output register
	logic    res_valid_q;
	result_t res_q;

	// accumulator state
	logic [COUNT_BITS-1:0] last_q;
	logic [COUNT_BITS-1:0] rev_start_q;
	logic [COUNT_BITS-1:0] rev_end_q;
	logic [TOTAL_BITS-1:0] total_q;
	mode_t                 mode_q;

	logic                  move;
	logic                  take;
	logic [COUNT_BITS-1:0] d_rs_ls;
	logic [COUNT_BITS-1:0] d_s_rs;
	logic [COUNT_BITS-1:0] d_re_rs;
	logic [COUNT_BITS-1:0] d_s_re;
	logic [COUNT_BITS-1:0] d_s_ls;
	logic [COUNT_BITS-1:0] rev_start_n;
	logic [COUNT_BITS-1:0] rev_end_n;
	logic [TOTAL_BITS-1:0] total_n;
	mode_t                 mode_mid;
	mode_t                 mode_n;

	// s1 hands its item to the result register when that register is free
	// or being emptied this cycle.
	assign move         = valid_s1 && (!res_valid_q || !result_stall);
	assign take         = sample_valid && !sample_stall;
	assign sample_stall = valid_s1 && !move;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// modular counter spans
	assign d_rs_ls = rev_start_q - last_q;
	assign d_s_rs  = item_s1.counter_sample - rev_start_q;
	assign d_re_rs = rev_end_q - rev_start_q;
	assign d_s_re  = item_s1.counter_sample - rev_end_q;
	assign d_s_ls  = item_s1.counter_sample - last_q;

	always_comb begin
		total_n     = total_q;
		rev_start_n = rev_start_q;
		rev_end_n   = rev_end_q;
		mode_mid    = mode_q;
		case (mode_q)
			MODE_REV: begin
				// pulses up to the reverse start count forward, the rest back
				total_n = total_q
					+ {{(TOTAL_BITS-COUNT_BITS){1'b0}}, d_rs_ls}
					- {{(TOTAL_BITS-COUNT_BITS){1'b0}}, d_s_rs};
				rev_start_n = item_s1.counter_sample;
			end
			MODE_END: begin
				// forward, then the closed reverse interval, then forward again
				total_n = total_q
					+ {{(TOTAL_BITS-COUNT_BITS){1'b0}}, d_rs_ls}
					- {{(TOTAL_BITS-COUNT_BITS){1'b0}}, d_re_rs}
					+ {{(TOTAL_BITS-COUNT_BITS){1'b0}}, d_s_re};
				rev_start_n = item_s1.counter_sample;
				rev_end_n   = item_s1.counter_sample;
				mode_mid    = MODE_FWD;
			end
			default: begin
				total_n = total_q + {{(TOTAL_BITS-COUNT_BITS){1'b0}}, d_s_ls};
			end
		endcase

		// pin check after the update
		mode_n = mode_mid;
		if (!item_s1.dir_pin) begin
			if (mode_mid != MODE_REV) begin
				rev_start_n = item_s1.dir_check_count;
				mode_n      = MODE_REV;
			end
		end else if (mode_mid == MODE_REV) begin
			rev_end_n = item_s1.dir_check_count;
			mode_n    = MODE_END;
		end
	end

	// control and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			last_q      <= '0;
			rev_start_q <= '0;
			rev_end_q   <= '0;
			total_q     <= '0;
			mode_q      <= MODE_FWD;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (move) begin
				last_q      <= item_s1.counter_sample;
				rev_start_q <= rev_start_n;
				rev_end_q   <= rev_end_n;
				total_q     <= total_n;
				mode_q      <= mode_n;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= sample;
		end
		if (move) begin
			res_q.pulse_total <= total_n;
			res_q.dir_mode    <= mode_n;
		end
	end

endmodule
`default_nettype wire

>>> src/dppa_checker.sv
// Port-level checker for the direction-pin pulse accumulator, with its bind.
`default_nettype none
`include "assert_macros.svh"
module dppa_checker
	import dppa_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    sample_valid,
	input wire logic    sample_stall,
	input wire sample_t sample,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	// input backs up only behind a stalled, pending result
	`ASSERT_IMP(a_stall_cause, clk, arst_n, sample_stall, result_valid && result_stall)

	// a result from empty comes from an item taken into the input register
	`ASSERT_IMP(a_latency, clk, arst_n, $rose(result_valid), $past(sample_valid && !sample_stall, 2))

	// a stalled result holds
	`ASSERT_NXT(a_res_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind direction_pin_pulse_accumulator dppa_checker u_dppa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.sample       (sample),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire
